// ===== rtl/range_map_table_core_macros.svh =====
// ----------------------------------------------------------------------------
// range_map_table_core_macros: assertion macros for the range map table
// Shared property forms used by the RTL assertion blocks.
// ----------------------------------------------------------------------------
`ifndef RANGE_MAP_TABLE_CORE_MACROS_SVH
`define RANGE_MAP_TABLE_CORE_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define RMT_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A trigger that must be followed by a consequence in the next cycle.
`define RMT_ASSERT_NEXT(name, trig, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rmt_pkg.sv =====
// ----------------------------------------------------------------------------
// rmt_pkg: shared types and codes for the range map table
// Entry, transfer payload and control structs, operation codes and states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmt_pkg;

    typedef enum logic [1:0] {
        MODE_SEARCH = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_NONE   = 2'd3
    } rmt_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIX,
        ST_DONE
    } rmt_state_t;

    typedef struct packed {
        logic [63:0] start;
        logic [63:0] length;
        logic [63:0] tag;
    } rmt_entry_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] start_key;
        logic [63:0] length;
        logic [63:0] tag_value;
    } rmt_in_t;

    typedef struct packed {
        logic        hit;
        logic [63:0] hit_start;
        logic [63:0] hit_length;
        logic [63:0] hit_tag;
        logic        status;
        logic [4:0]  entry_count;
    } rmt_out_t;

    // Pieces that one held range turns into, in table order.
    typedef struct packed {
        logic                 overlap;
        logic                 uses_new;
        logic [1:0]           count;
        rmt_entry_t [2:0]     piece;
    } rmt_piece_t;

endpackage

// ===== rtl/range_map_table_core.sv =====
// ----------------------------------------------------------------------------
// range_map_table_core: sorted table of disjoint address ranges with tags
// Search, add with split on overlap, and delete over a chain of range cells.
// ----------------------------------------------------------------------------
// Usage. Items arrive on in_valid/in_ready with in_data and results leave on
// out_valid/out_ready with out_data, one result per item. The held ranges sit
// in a chain of CAPACITY+1 cells that shifts toward cell 0; one splitting
// unit looks at the head cell each cycle.
// Every item first rotates the n held ranges once through the chain to find
// a search hit and count the resulting ranges. An update that fits then
// streams the ranges out of the head and writes the pieces back at the fill
// point, one piece a cycle. A search, an unused mode, a zero-length or a
// refused update goes from the scan straight to the output register; an
// applied update passes through the fix phase first.
// One item is in work at a time; the next one is taken once the result is
// loaded into the output register, even while the receiver stalls that
// result. A stalled result holds the following item in its last state.
// Reset empties the table at once (count cleared); cell contents are not
// cleared and are never read before they are written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "range_map_table_core_macros.svh"

module range_map_table_core
    import rmt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  rmt_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output rmt_out_t out_data
);

    localparam int CW = $clog2(CAPACITY + 3);

    rmt_state_t  state_reg, state_next;
    rmt_in_t     q_reg;
    logic [64:0] kend_reg;
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] acc_reg, acc_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic [1:0]  ph_reg, ph_next;
    logic        pend_reg, pend_next;
    logic        hit_reg, hit_next;
    rmt_entry_t  hent_reg, hent_next;
    logic        ovf_reg, ovf_next;
    logic        out_valid_reg;
    rmt_out_t    out_reg;

    logic          shift;
    logic          wr;
    logic [CW-1:0] wptr;
    rmt_entry_t    wdata;
    rmt_entry_t    fresh;
    rmt_piece_t    pc;
    logic          is_add;
    logic          do_update;
    logic          scanning;
    logic          fixing;
    logic          last_piece;
    logic [CW-1:0] total;
    logic          load_out;

    rmt_entry_t cell_q [CAPACITY+1];

    // Chain of range cells; the top cell has no upper neighbor.
    for (genvar i = 0; i <= CAPACITY; i++)
    begin : g_cell
        rmt_cell #(.IDX(i), .CW(CW)) u_cell (
            .clk   (clk),
            .shift (shift),
            .wr    (wr),
            .wptr  (wptr),
            .nbr   (cell_q[(i < CAPACITY) ? i + 1 : i]),
            .piece (wdata),
            .entry (cell_q[i])
        );
    end

    assign fresh = '{start: q_reg.start_key, length: q_reg.length, tag: q_reg.tag_value};

    rmt_piece u_piece (
        .head    (cell_q[0]),
        .fresh   (fresh),
        .kend    (kend_reg),
        .pending (pend_reg),
        .res     (pc)
    );

    assign is_add    = q_reg.mode == MODE_ADD;
    assign do_update = (is_add || (q_reg.mode == MODE_DELETE)) && (q_reg.length != 64'd0);
    assign scanning  = (state_reg == ST_SCAN) && (cnt_reg != used_reg);
    assign fixing    = (state_reg == ST_FIX) && (cnt_reg != used_reg);
    assign last_piece = (pc.count == 2'd0) || (ph_reg == pc.count - 2'd1);
    assign total     = acc_reg + CW'(pend_reg);
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == used_reg)
                begin
                    state_next = (do_update && !(total > CW'(CAPACITY))) ? ST_FIX : ST_DONE;
                end
            end
            ST_FIX:
            begin
                if ((cnt_reg == used_reg) && !pend_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Chain controls: rotation while scanning, piece writes while fixing.
    always_comb
    begin
        shift = 1'b0;
        wr    = 1'b0;
        wptr  = occ_reg;
        wdata = pc.piece[ph_reg];
        if (scanning)
        begin
            shift = 1'b1;
            wr    = 1'b1;
            wptr  = used_reg - CW'(1);
            wdata = cell_q[0];
        end
        else if (fixing)
        begin
            shift = last_piece;
            wr    = pc.count != 2'd0;
            wptr  = last_piece ? occ_reg - CW'(1) : occ_reg;
        end
        else if ((state_reg == ST_FIX) && pend_reg)
        begin
            wr    = 1'b1;
            wdata = fresh;
        end
    end

    // Sequencer counters and result capture.
    always_comb
    begin
        in_ready  = state_reg == ST_IDLE;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        occ_next  = occ_reg - CW'(shift) + CW'(wr);
        ph_next   = ph_reg;
        pend_next = pend_reg;
        hit_next  = hit_reg;
        hent_next = hent_reg;
        ovf_next  = ovf_reg;
        used_next = used_reg;
        if (state_reg == ST_IDLE)
        begin
            cnt_next  = '0;
            acc_next  = '0;
            ph_next   = 2'd0;
            pend_next = in_data.mode == MODE_ADD;
            hit_next  = 1'b0;
            hent_next = '0;
            ovf_next  = 1'b0;
            occ_next  = used_reg;
        end
        else if (scanning)
        begin
            cnt_next  = cnt_reg + CW'(1);
            acc_next  = acc_reg + CW'(pc.count);
            pend_next = pend_reg && !pc.uses_new;
            occ_next  = used_reg;
            if ((q_reg.mode == MODE_SEARCH) && !hit_reg && pc.overlap)
            begin
                hit_next  = 1'b1;
                hent_next = cell_q[0];
            end
        end
        else if (state_reg == ST_SCAN)
        begin
            cnt_next  = '0;
            ph_next   = 2'd0;
            pend_next = is_add;
            occ_next  = used_reg;
            ovf_next  = do_update && (total > CW'(CAPACITY));
        end
        else if (fixing)
        begin
            if (last_piece)
            begin
                cnt_next  = cnt_reg + CW'(1);
                ph_next   = 2'd0;
                pend_next = pend_reg && !pc.uses_new;
            end
            else
            begin
                ph_next = ph_reg + 2'd1;
            end
        end
        else if (state_reg == ST_FIX)
        begin
            pend_next = 1'b0;
            if (!pend_reg)
            begin
                used_next = occ_reg;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            occ_reg       <= '0;
            ph_reg        <= 2'd0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            occ_reg   <= occ_next;
            ph_reg    <= ph_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
            ovf_reg   <= ovf_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: query, its end, hit range and the result.
    always_ff @(posedge clk)
    begin
        hent_reg <= hent_next;
        if (in_valid && in_ready)
        begin
            q_reg    <= in_data;
            kend_reg <= {1'b0, in_data.start_key} + {1'b0, in_data.length};
        end
        if (load_out)
        begin
            out_reg.hit         <= hit_reg;
            out_reg.hit_start   <= hent_reg.start;
            out_reg.hit_length  <= hent_reg.length;
            out_reg.hit_tag     <= hent_reg.tag;
            out_reg.status      <= ovf_reg;
            out_reg.entry_count <= 5'(used_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `RMT_ASSERT_ALWAYS(a_used_cap, used_reg <= CW'(CAPACITY), "table count above capacity")
    `RMT_ASSERT_ALWAYS(a_occ_cap, occ_reg <= CW'(CAPACITY + 1), "chain fill beyond last cell")
    `RMT_ASSERT_NEXT(a_busy, in_valid && in_ready, state_reg == ST_SCAN, "accepted item not scanned")
    `RMT_ASSERT_NEXT(a_ovf_keep, (state_reg == ST_SCAN) && (state_next == ST_DONE) && do_update,
                     used_reg == $past(used_reg), "refused update changed the table")

endmodule

// ===== rtl/rmt_cell.sv =====
// ----------------------------------------------------------------------------
// rmt_cell: one slot of the range chain
// Holds one range; shifts from its upper neighbor or takes a written piece.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmt_cell
    import rmt_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
)
(
    input  logic          clk,
    input  logic          shift,
    input  logic          wr,
    input  logic [CW-1:0] wptr,
    input  rmt_entry_t    nbr,
    input  rmt_entry_t    piece,
    output rmt_entry_t    entry
);

    rmt_entry_t entry_reg;
    rmt_entry_t entry_next;

    // A write aimed at this slot wins over the shift.
    always_comb
    begin
        entry_next = shift ? nbr : entry_reg;
        if (wr && (wptr == CW'(IDX)))
        begin
            entry_next = piece;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/rmt_piece.sv =====
// ----------------------------------------------------------------------------
// rmt_piece: splits the head range against the query range
// Gives the overlap flag and the ordered pieces that replace the range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmt_piece
    import rmt_pkg::*;
(
    input  rmt_entry_t  head,
    input  rmt_entry_t  fresh,
    input  logic [64:0] kend,
    input  logic        pending,
    output rmt_piece_t  res
);

    logic [64:0] aend;
    logic        has_l;
    logic        has_r;
    logic        put_new;
    rmt_entry_t  left;
    rmt_entry_t  right;

    always_comb
    begin
        aend    = {1'b0, head.start} + {1'b0, head.length};
        has_l   = head.start < fresh.start;
        has_r   = !kend[64] && (kend < aend);
        left    = '{start: head.start, length: fresh.start - head.start, tag: head.tag};
        right   = '{start: kend[63:0], length: aend[63:0] - kend[63:0], tag: head.tag};
        res     = '0;
        res.overlap = (fresh.length != 64'd0) && (head.length != 64'd0)
                      && ({1'b0, fresh.start} < aend) && ({1'b0, head.start} < kend);
        put_new = 1'b0;
        if (!res.overlap)
        begin
            // The new range goes in front of the first range above it.
            if (pending && (head.start > fresh.start))
            begin
                res.piece[0] = fresh;
                res.piece[1] = head;
                res.count    = 2'd2;
                res.uses_new = 1'b1;
            end
            else
            begin
                res.piece[0] = head;
                res.count    = 2'd1;
            end
        end
        else
        begin
            // Order is left piece, new range, right piece.
            put_new      = pending && has_r;
            res.uses_new = put_new;
            res.piece[0] = has_l ? left : (put_new ? fresh : right);
            res.piece[1] = has_l ? (put_new ? fresh : right) : right;
            res.piece[2] = right;
            res.count    = 2'({1'b0, has_l}) + 2'({1'b0, put_new}) + 2'({1'b0, has_r});
        end
    end

endmodule
